// ===== rtl/core/cm2d_pkg.sv =====
// Shared constants for the capsule merge pipeline: default coordinate width,
// endpoint count and the table of endpoint pairs. No dependencies.
package cm2d_pkg;

    localparam int unsigned COORD_BITS_DEF = 24;
    localparam int unsigned NUM_PTS        = 4;
    localparam int unsigned NUM_PAIRS      = 6;

    typedef logic [2:0] t_pair_idx;

    // Endpoint pairs in test order; lower index is the merged start point
    localparam logic [1:0] PAIR_LO [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_HI [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

// ===== rtl/core/cm2d_pair.sv =====
// Farthest-pair search over the four endpoints: differences, squares, sums,
// two-level first-maximum selection. Depends on cm2d_pkg.
module cm2d_pair #(
    parameter int unsigned COORD_BITS = cm2d_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [COORD_BITS-1:0]   i_px [cm2d_pkg::NUM_PTS],
    input  logic [COORD_BITS-1:0]   i_py [cm2d_pkg::NUM_PTS],
    input  logic [COORD_BITS-2:0]   i_rad_first,
    input  logic [COORD_BITS-2:0]   i_rad_second,
    output logic                    o_valid,
    output logic [COORD_BITS-1:0]   o_px [cm2d_pkg::NUM_PTS],
    output logic [COORD_BITS-1:0]   o_py [cm2d_pkg::NUM_PTS],
    output logic [6*COORD_BITS-3:0] o_side
);
    import cm2d_pkg::*;

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned NS = 5;
    localparam int unsigned DW = C + 1;
    localparam int unsigned SW = 2 * C + 2;

    logic [NS-1:0]        r_v;
    logic [C-1:0]         r_px [NS][NUM_PTS];
    logic [C-1:0]         r_py [NS][NUM_PTS];
    logic [C-2:0]         r_ra [NS-1];
    logic [C-2:0]         r_rb [NS-1];
    logic signed [DW-1:0] r_dx [NUM_PAIRS];
    logic signed [DW-1:0] r_dy [NUM_PAIRS];
    logic signed [DW-1:0] n_dx [NUM_PAIRS];
    logic signed [DW-1:0] n_dy [NUM_PAIRS];
    logic signed [SW-1:0] r_sx [NUM_PAIRS];
    logic signed [SW-1:0] r_sy [NUM_PAIRS];
    logic signed [SW-1:0] n_sx [NUM_PAIRS];
    logic signed [SW-1:0] n_sy [NUM_PAIRS];
    logic [SW-1:0]        r_d  [NUM_PAIRS];
    logic [SW-1:0]        n_d  [NUM_PAIRS];
    logic [SW-1:0]        r_gv [2];
    logic [SW-1:0]        n_gv [2];
    t_pair_idx            r_gi [2];
    t_pair_idx            n_gi [2];
    t_pair_idx            w_sel;
    logic [6*C-3:0]       r_side;
    logic [6*C-3:0]       n_side;

    always_comb begin
        for (int p = 0; p < NUM_PAIRS; p++) begin
            n_dx[p] = $signed({i_px[PAIR_HI[p]][C-1], i_px[PAIR_HI[p]]})
                    - $signed({i_px[PAIR_LO[p]][C-1], i_px[PAIR_LO[p]]});
            n_dy[p] = $signed({i_py[PAIR_HI[p]][C-1], i_py[PAIR_HI[p]]})
                    - $signed({i_py[PAIR_LO[p]][C-1], i_py[PAIR_LO[p]]});
            n_sx[p] = r_dx[p] * r_dx[p];
            n_sy[p] = r_dy[p] * r_dy[p];
            n_d[p]  = $unsigned(r_sx[p]) + $unsigned(r_sy[p]);
        end
        // first maximum within each group of three; later entries win only when larger
        for (int g = 0; g < 2; g++) begin
            n_gi[g] = t_pair_idx'(3 * g);
            n_gv[g] = r_d[3 * g];
            for (int m = 1; m < 3; m++) begin
                if (r_d[3 * g + m] > n_gv[g]) begin
                    n_gv[g] = r_d[3 * g + m];
                    n_gi[g] = t_pair_idx'(3 * g + m);
                end
            end
        end
        w_sel  = (r_gv[1] > r_gv[0]) ? r_gi[1] : r_gi[0];
        n_side = {r_rb[NS-2], r_ra[NS-2],
                  r_py[NS-2][PAIR_HI[w_sel]], r_px[NS-2][PAIR_HI[w_sel]],
                  r_py[NS-2][PAIR_LO[w_sel]], r_px[NS-2][PAIR_LO[w_sel]]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px[0] <= i_px;
            r_py[0] <= i_py;
            r_ra[0] <= i_rad_first;
            r_rb[0] <= i_rad_second;
            for (int s = 1; s < NS; s++) begin
                r_px[s] <= r_px[s-1];
                r_py[s] <= r_py[s-1];
            end
            for (int s = 1; s < NS - 1; s++) begin
                r_ra[s] <= r_ra[s-1];
                r_rb[s] <= r_rb[s-1];
            end
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_d    <= n_d;
            r_gv   <= n_gv;
            r_gi   <= n_gi;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_px    = r_px[NS-1];
    assign o_py    = r_py[NS-1];
    assign o_side  = r_side;

endmodule

// ===== rtl/core/cm2d_geom.sv =====
// Point-to-segment geometry for the four endpoints: dot and cross products,
// clamp decision, exact squared cross term. Emits root operands. Depends on cm2d_pkg.
module cm2d_geom #(
    parameter int unsigned COORD_BITS = cm2d_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [COORD_BITS-1:0]   i_px [cm2d_pkg::NUM_PTS],
    input  logic [COORD_BITS-1:0]   i_py [cm2d_pkg::NUM_PTS],
    input  logic [6*COORD_BITS-3:0] i_side,
    output logic                    o_valid,
    output logic [4*COORD_BITS+3:0] o_num [cm2d_pkg::NUM_PTS],
    output logic [2*COORD_BITS+1:0] o_den [cm2d_pkg::NUM_PTS],
    output logic [6*COORD_BITS-3:0] o_side
);
    import cm2d_pkg::*;

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned NS = 6;
    localparam int unsigned DW = C + 1;
    localparam int unsigned PW = 2 * C + 2;
    localparam int unsigned SW = 2 * C + 2;
    localparam int unsigned QW = 2 * C + 3;
    localparam int unsigned MW = 2 * C + 2;
    localparam int unsigned HW = (MW + 1) / 2;
    localparam int unsigned LW = MW - HW;
    localparam int unsigned NW = 2 * MW;

    logic [NS-1:0]        r_v;
    logic [6*C-3:0]       r_side [NS];
    logic [C-1:0]         w_ax, w_ay, w_bx, w_by;

    // stage 1
    logic signed [DW-1:0] r_dx, r_dy, n_dx, n_dy;
    logic signed [DW-1:0] r_ex [NUM_PTS], r_ey [NUM_PTS], r_fx [NUM_PTS], r_fy [NUM_PTS];
    logic signed [DW-1:0] n_ex [NUM_PTS], n_ey [NUM_PTS], n_fx [NUM_PTS], n_fy [NUM_PTS];
    // stage 2
    logic signed [PW-1:0] r_dxx, r_dyy;
    logic signed [PW-1:0] r_pd1 [NUM_PTS], r_pd2 [NUM_PTS], r_pc1 [NUM_PTS], r_pc2 [NUM_PTS];
    logic signed [PW-1:0] r_pex [NUM_PTS], r_pey [NUM_PTS], r_pfx [NUM_PTS], r_pfy [NUM_PTS];
    // stage 3
    logic [SW-1:0]        r_len3;
    logic signed [QW-1:0] r_dot [NUM_PTS], r_crs [NUM_PTS];
    logic [SW-1:0]        r_ea3 [NUM_PTS], r_fb3 [NUM_PTS];
    // stage 4
    logic [SW-1:0]        r_len4;
    logic                 r_na4 [NUM_PTS], r_nb4 [NUM_PTS];
    logic                 n_na4 [NUM_PTS], n_nb4 [NUM_PTS];
    logic [MW-1:0]        r_cm  [NUM_PTS], n_cm [NUM_PTS];
    logic [SW-1:0]        r_ea4 [NUM_PTS], r_fb4 [NUM_PTS];
    // stage 5
    logic [SW-1:0]        r_len5;
    logic                 r_na5 [NUM_PTS], r_nb5 [NUM_PTS];
    logic [2*HW-1:0]      r_hh  [NUM_PTS];
    logic [HW+LW-1:0]     r_hl  [NUM_PTS];
    logic [2*LW-1:0]      r_ll  [NUM_PTS];
    logic [SW-1:0]        r_ea5 [NUM_PTS], r_fb5 [NUM_PTS];
    // stage 6
    logic [NW-1:0]        r_num [NUM_PTS], n_num [NUM_PTS];
    logic [SW-1:0]        r_den [NUM_PTS], n_den [NUM_PTS];

    assign w_ax = i_side[0 +: C];
    assign w_ay = i_side[C +: C];
    assign w_bx = i_side[2*C +: C];
    assign w_by = i_side[3*C +: C];

    always_comb begin
        logic signed [QW-1:0] v_neg;
        logic [NW-1:0]        v_c2;
        v_neg = '0;
        v_c2  = '0;
        n_dx = $signed({w_bx[C-1], w_bx}) - $signed({w_ax[C-1], w_ax});
        n_dy = $signed({w_by[C-1], w_by}) - $signed({w_ay[C-1], w_ay});
        for (int l = 0; l < NUM_PTS; l++) begin
            n_ex[l] = $signed({i_px[l][C-1], i_px[l]}) - $signed({w_ax[C-1], w_ax});
            n_ey[l] = $signed({i_py[l][C-1], i_py[l]}) - $signed({w_ay[C-1], w_ay});
            n_fx[l] = $signed({i_px[l][C-1], i_px[l]}) - $signed({w_bx[C-1], w_bx});
            n_fy[l] = $signed({i_py[l][C-1], i_py[l]}) - $signed({w_by[C-1], w_by});

            // clamp: behind the start, beyond the end, or perpendicular
            n_na4[l] = r_dot[l][QW-1] || (r_dot[l] == '0);
            n_nb4[l] = !n_na4[l] && (r_dot[l] >= $signed({1'b0, r_len3}));
            v_neg    = -r_crs[l];
            n_cm[l]  = r_crs[l][QW-1] ? v_neg[MW-1:0] : r_crs[l][MW-1:0];

            v_c2 = (NW'(r_hh[l]) << (2 * LW)) + (NW'(r_hl[l]) << (LW + 1)) + NW'(r_ll[l]);
            if (r_na5[l]) begin
                n_num[l] = NW'(r_ea5[l]);
                n_den[l] = SW'(1);
            end else if (r_nb5[l]) begin
                n_num[l] = NW'(r_fb5[l]);
                n_den[l] = SW'(1);
            end else begin
                n_num[l] = v_c2;
                n_den[l] = r_len5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < NS; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_dxx  <= r_dx * r_dx;
            r_dyy  <= r_dy * r_dy;
            r_len3 <= $unsigned(r_dxx) + $unsigned(r_dyy);
            r_len4 <= r_len3;
            r_len5 <= r_len4;
            for (int l = 0; l < NUM_PTS; l++) begin
                r_ex[l]  <= n_ex[l];
                r_ey[l]  <= n_ey[l];
                r_fx[l]  <= n_fx[l];
                r_fy[l]  <= n_fy[l];
                r_pd1[l] <= r_ex[l] * r_dx;
                r_pd2[l] <= r_ey[l] * r_dy;
                r_pc1[l] <= r_ex[l] * r_dy;
                r_pc2[l] <= r_ey[l] * r_dx;
                r_pex[l] <= r_ex[l] * r_ex[l];
                r_pey[l] <= r_ey[l] * r_ey[l];
                r_pfx[l] <= r_fx[l] * r_fx[l];
                r_pfy[l] <= r_fy[l] * r_fy[l];
                r_dot[l] <= QW'(r_pd1[l]) + QW'(r_pd2[l]);
                r_crs[l] <= QW'(r_pc1[l]) - QW'(r_pc2[l]);
                r_ea3[l] <= $unsigned(r_pex[l]) + $unsigned(r_pey[l]);
                r_fb3[l] <= $unsigned(r_pfx[l]) + $unsigned(r_pfy[l]);
                r_na4[l] <= n_na4[l];
                r_nb4[l] <= n_nb4[l];
                r_cm[l]  <= n_cm[l];
                r_ea4[l] <= r_ea3[l];
                r_fb4[l] <= r_fb3[l];
                r_na5[l] <= r_na4[l];
                r_nb5[l] <= r_nb4[l];
                r_hh[l]  <= r_cm[l][MW-1:LW] * r_cm[l][MW-1:LW];
                r_hl[l]  <= r_cm[l][MW-1:LW] * r_cm[l][LW-1:0];
                r_ll[l]  <= r_cm[l][LW-1:0] * r_cm[l][LW-1:0];
                r_ea5[l] <= r_ea4[l];
                r_fb5[l] <= r_fb4[l];
                r_num[l] <= n_num[l];
                r_den[l] <= n_den[l];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side[NS-1];

endmodule

// ===== rtl/core/cm2d_root.sv =====
// Pipelined ceiling square root of num/den for four lanes, one result bit per
// stage by shift-and-subtract on the exact remainder. Depends on cm2d_pkg.
module cm2d_root #(
    parameter int unsigned COORD_BITS = cm2d_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [4*COORD_BITS+3:0] i_num [cm2d_pkg::NUM_PTS],
    input  logic [2*COORD_BITS+1:0] i_den [cm2d_pkg::NUM_PTS],
    input  logic [6*COORD_BITS-3:0] i_side,
    output logic                    o_valid,
    output logic [COORD_BITS-1:0]   o_dist [cm2d_pkg::NUM_PTS],
    output logic [6*COORD_BITS-3:0] o_side
);
    import cm2d_pkg::*;

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned NS = C - 1;
    localparam int unsigned RB = C - 1;
    localparam int unsigned SW = 2 * C + 2;
    localparam int unsigned NW = 4 * C + 4;

    logic [NS-1:0]  r_v;
    logic [6*C-3:0] r_side [NS];
    logic [NW-1:0]  r_rem [NS][NUM_PTS], n_rem [NS][NUM_PTS];
    logic [NW-1:0]  r_acc [NS][NUM_PTS], n_acc [NS][NUM_PTS];
    logic [SW-1:0]  r_den [NS][NUM_PTS], n_den [NS][NUM_PTS];
    logic [RB-1:0]  r_n   [NS][NUM_PTS], n_n   [NS][NUM_PTS];
    logic           r_nz  [NS][NUM_PTS], n_nz  [NS][NUM_PTS];

    // Find the largest n with n*n*den < num; the ceiling root is n + 1 unless num is zero.
    // rem holds num - n*n*den, acc holds n*den.
    always_comb begin
        logic [NW-1:0] v_rem, v_acc, v_dk, v_inc;
        logic [SW-1:0] v_den;
        logic [RB-1:0] v_n;
        logic          v_nz;
        for (int s = 0; s < NS; s++) begin
            for (int l = 0; l < NUM_PTS; l++) begin
                if (s == 0) begin
                    v_rem = i_num[l];
                    v_acc = '0;
                    v_den = i_den[l];
                    v_n   = '0;
                    v_nz  = |i_num[l];
                end else begin
                    v_rem = r_rem[s-1][l];
                    v_acc = r_acc[s-1][l];
                    v_den = r_den[s-1][l];
                    v_n   = r_n[s-1][l];
                    v_nz  = r_nz[s-1][l];
                end
                v_dk  = NW'(v_den) << (NS - 1 - s);
                v_inc = (v_acc << (NS - s)) + (v_dk << (NS - 1 - s));
                n_den[s][l] = v_den;
                n_nz[s][l]  = v_nz;
                if (v_inc < v_rem) begin
                    n_rem[s][l] = v_rem - v_inc;
                    n_acc[s][l] = v_acc + v_dk;
                    n_n[s][l]   = v_n | (RB'(1) << (NS - 1 - s));
                end else begin
                    n_rem[s][l] = v_rem;
                    n_acc[s][l] = v_acc;
                    n_n[s][l]   = v_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < NS; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_den <= n_den;
            r_n   <= n_n;
            r_nz  <= n_nz;
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_PTS; l++) begin
            o_dist[l] = C'(r_n[NS-1][l]) + C'(r_nz[NS-1][l]);
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// ===== rtl/core/cm2d_skid.sv =====
// Two-entry output buffer: registered output word plus one skid word, so the
// pipeline enable depends on a register only. No dependencies.
module cm2d_skid #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_ready
);
    logic             r_o_v, r_s_v;
    logic [WIDTH-1:0] r_o_d, r_s_d;

    assign o_ready = !r_s_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (!r_o_v || i_ready) begin
            if (r_s_v) begin
                r_o_v <= 1'b1;
                r_s_v <= 1'b0;
            end else begin
                r_o_v <= i_valid;
            end
        end else if (i_valid && !r_s_v) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || i_ready) begin
            r_o_d <= r_s_v ? r_s_d : i_data;
        end else if (!r_s_v) begin
            // hold the incoming word while the output is stalled
            r_s_d <= i_data;
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_o_d;

endmodule

// ===== rtl/core/capsule_merge_2d.sv =====
// Throughput: one word per cycle while the output is not stalled; depth is set by
// the square-root pipeline, one stage per radius bit (COORD_BITS - 1 stages), four
// lanes side by side.
// Reset (synchronous, active low) clears all valid bits and the output buffer;
// the datapath registers are not reset.
module capsule_merge_2d #(
    parameter  int unsigned COORD_BITS = cm2d_pkg::COORD_BITS_DEF,
    localparam int unsigned IN_W       = ((10 * COORD_BITS + 5) / 8) * 8,
    localparam int unsigned OUT_W      = ((5 * COORD_BITS + 6) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // first_a_x, first_a_y, first_b_x, first_b_y, first_radius,
    // second_a_x, second_a_y, second_b_x, second_b_y, second_radius
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // merged_a_x, merged_a_y, merged_b_x, merged_b_y, merged_radius
    output logic [OUT_W-1:0] o_m_tdata,
    // radius_saturated
    output logic [0:0]       o_m_tuser
);
    import cm2d_pkg::*;

    localparam int unsigned C   = COORD_BITS;
    localparam int unsigned NF  = 3;
    localparam int unsigned SKW = 5 * C;
    localparam logic [C:0]  RAD_MAX = {2'b00, {(C - 1){1'b1}}};

    logic             w_en;
    logic [C-1:0]     w_px [NUM_PTS];
    logic [C-1:0]     w_py [NUM_PTS];
    logic [C-2:0]     w_r1, w_r2;

    logic             w_p_v;
    logic [C-1:0]     w_p_px [NUM_PTS];
    logic [C-1:0]     w_p_py [NUM_PTS];
    logic [6*C-3:0]   w_p_side;

    logic             w_g_v;
    logic [4*C+3:0]   w_g_num [NUM_PTS];
    logic [2*C+1:0]   w_g_den [NUM_PTS];
    logic [6*C-3:0]   w_g_side;

    logic             w_r_v;
    logic [C-1:0]     w_r_dist [NUM_PTS];
    logic [6*C-3:0]   w_r_side;

    logic [NF-1:0]    r_fv;
    logic [4*C-1:0]   r_xy [NF];
    logic [C-2:0]     r_need [NUM_PTS], n_need [NUM_PTS];
    logic             r_sat1 [NUM_PTS], n_sat1 [NUM_PTS];
    logic [C-2:0]     r_base1, r_base2, n_base1;
    logic [C-2:0]     r_m01, r_m23;
    logic             r_sat2, r_sat3;
    logic [C-2:0]     r_rad, n_rad;
    logic [C-2:0]     w_mq;

    logic [SKW-1:0]   w_sk_out;

    assign w_px[0] = i_s_tdata[0 +: C];
    assign w_py[0] = i_s_tdata[C +: C];
    assign w_px[1] = i_s_tdata[2*C +: C];
    assign w_py[1] = i_s_tdata[3*C +: C];
    assign w_r1    = i_s_tdata[4*C +: C-1];
    assign w_px[2] = i_s_tdata[5*C-1 +: C];
    assign w_py[2] = i_s_tdata[6*C-1 +: C];
    assign w_px[3] = i_s_tdata[7*C-1 +: C];
    assign w_py[3] = i_s_tdata[8*C-1 +: C];
    assign w_r2    = i_s_tdata[9*C-1 +: C-1];

    assign o_s_tready = w_en;

    cm2d_pair #(.COORD_BITS(COORD_BITS)) u_pair (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_s_tvalid),
        .i_px         (w_px),
        .i_py         (w_py),
        .i_rad_first  (w_r1),
        .i_rad_second (w_r2),
        .o_valid      (w_p_v),
        .o_px         (w_p_px),
        .o_py         (w_p_py),
        .o_side       (w_p_side)
    );

    cm2d_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p_v),
        .i_px    (w_p_px),
        .i_py    (w_p_py),
        .i_side  (w_p_side),
        .o_valid (w_g_v),
        .o_num   (w_g_num),
        .o_den   (w_g_den),
        .o_side  (w_g_side)
    );

    cm2d_root #(.COORD_BITS(COORD_BITS)) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_g_v),
        .i_num   (w_g_num),
        .i_den   (w_g_den),
        .i_side  (w_g_side),
        .o_valid (w_r_v),
        .o_dist  (w_r_dist),
        .o_side  (w_r_side)
    );

    // distance plus own radius, clipped at the maximum radius
    always_comb begin
        logic [C:0] v_need;
        logic [C-2:0] v_r0, v_r2;
        v_r0 = w_r_side[4*C +: C-1];
        v_r2 = w_r_side[5*C-1 +: C-1];
        for (int l = 0; l < NUM_PTS; l++) begin
            v_need    = (C+1)'(w_r_dist[l]) + (C+1)'((l < 2) ? v_r0 : v_r2);
            n_sat1[l] = v_need > RAD_MAX;
            n_need[l] = n_sat1[l] ? RAD_MAX[C-2:0] : v_need[C-2:0];
        end
        n_base1 = (v_r0 > v_r2) ? v_r0 : v_r2;
        w_mq    = (r_m01 > r_m23) ? r_m01 : r_m23;
        n_rad   = (w_mq > r_base2) ? w_mq : r_base2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[NF-2:0], w_r_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xy[0] <= w_r_side[4*C-1:0];
            for (int s = 1; s < NF; s++) begin
                r_xy[s] <= r_xy[s-1];
            end
            r_need  <= n_need;
            r_sat1  <= n_sat1;
            r_base1 <= n_base1;
            r_m01   <= (r_need[0] > r_need[1]) ? r_need[0] : r_need[1];
            r_m23   <= (r_need[2] > r_need[3]) ? r_need[2] : r_need[3];
            r_base2 <= r_base1;
            r_sat2  <= r_sat1[0] | r_sat1[1] | r_sat1[2] | r_sat1[3];
            r_rad   <= n_rad;
            r_sat3  <= r_sat2;
        end
    end

    cm2d_skid #(.WIDTH(SKW)) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fv[NF-1]),
        .i_data  ({r_sat3, r_rad, r_xy[NF-1]}),
        .o_ready (w_en),
        .o_valid (o_m_tvalid),
        .o_data  (w_sk_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = OUT_W'(w_sk_out[SKW-2:0]);
    assign o_m_tuser = w_sk_out[SKW-1];

endmodule

// ===== rtl/core/cm2d_checker.sv =====
// Port-level checks for capsule_merge_2d, bound to the top level.
// Depends on cm2d_pkg for the default coordinate width.
module cm2d_checker #(
    parameter  int unsigned COORD_BITS = cm2d_pkg::COORD_BITS_DEF,
    localparam int unsigned OUT_W      = ((5 * COORD_BITS + 6) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata,
    input logic [0:0]       o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[4*COORD_BITS +: COORD_BITS-1] == '1)
        else $error("saturation flag without maximum radius");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output not empty after reset");

    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready && i_s_tvalid == i_s_tvalid))
        else $error("input stalled without output back-pressure");

endmodule

bind capsule_merge_2d cm2d_checker #(.COORD_BITS(COORD_BITS)) u_cm2d_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for capsule_merge_2d: streams capsule pairs, predicts the
// bounding capsule of each pair and checks every output word against it.
// Depends on cm2d_pkg and the capsule_merge_2d RTL.
module tb_top;
    import cm2d_pkg::*;

    localparam int CB       = COORD_BITS_DEF;
    localparam int IN_W     = ((10 * CB + 5) / 8) * 8;
    localparam int OUT_W    = ((5 * CB + 6) / 8) * 8;
    localparam longint RMAX = (64'd1 << (CB - 1)) - 1;
    localparam int N_RAND   = 780;
    localparam int QUIET_N  = 120;
    localparam int WDOG_MAX = 4000;
    localparam int TAIL_CYC = CB + 40;

    typedef struct packed {
        logic signed [CB-1:0] ax, ay, bx, by;
        logic [CB-2:0]        r;
    } capsule_t;

    typedef struct packed {
        capsule_t c1, c0;
    } capsule_pair_t;

    typedef struct packed {
        logic        sat;
        logic [CB-2:0] r;
        logic signed [CB-1:0] by, bx, ay, ax;
    } merged_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tready = 1'b0;
    logic o_s_tready, o_m_tvalid;
    logic [OUT_W-1:0] o_m_tdata;
    logic [0:0] o_m_tuser;

    capsule_merge_2d DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    capsule_pair_t pending_q[$];
    merged_t       merged_q[$];
    capsule_pair_t cur_pair;
    int  total_items = 0;
    int  words_sent = 0;
    int  drain_at = 400;
    int  n_errors = 0;
    int  wdog = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  quiet = 1'b0;

    // smallest n with n*n*den >= num, or RMAX+1 if none fits
    function automatic longint ceil_root(logic [127:0] num, logic [127:0] den);
        longint lo, hi, mid;
        logic [127:0] t;
        lo = 0;
        hi = RMAX + 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            t = 128'(mid) * 128'(mid) * den;
            if (t >= num) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic longint seg_gap(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
        longint dx, dy, ex, ey, len2, dot, cr;
        logic [127:0] c;
        dx = bx - ax;
        dy = by - ay;
        ex = px - ax;
        ey = py - ay;
        len2 = dx * dx + dy * dy;
        dot = ex * dx + ey * dy;
        if (len2 == 0 || dot <= 0) return ceil_root(128'(ex * ex + ey * ey), 128'd1);
        if (dot >= len2)
            return ceil_root(128'((px - bx) * (px - bx) + (py - by) * (py - by)), 128'd1);
        cr = ex * dy - ey * dx;
        if (cr < 0) cr = -cr;
        c = 128'(cr);
        return ceil_root(c * c, 128'(len2));
    endfunction

    function automatic merged_t merge_capsules(capsule_pair_t cp);
        longint px[4], py[4], rad[4];
        longint d, best, r, need;
        int bi, bj, i, j;
        merged_t m;
        px[0] = cp.c0.ax; py[0] = cp.c0.ay; px[1] = cp.c0.bx; py[1] = cp.c0.by;
        px[2] = cp.c1.ax; py[2] = cp.c1.ay; px[3] = cp.c1.bx; py[3] = cp.c1.by;
        rad[0] = longint'(cp.c0.r); rad[1] = rad[0];
        rad[2] = longint'(cp.c1.r); rad[3] = rad[2];
        best = -1;
        bi = 0;
        bj = 1;
        // first maximum wins a tie
        for (int k = 0; k < NUM_PAIRS; k++) begin
            i = PAIR_LO[k];
            j = PAIR_HI[k];
            d = (px[j] - px[i]) * (px[j] - px[i]) + (py[j] - py[i]) * (py[j] - py[i]);
            if (d > best) begin
                best = d;
                bi = i;
                bj = j;
            end
        end
        r = rad[0] > rad[2] ? rad[0] : rad[2];
        m.sat = 1'b0;
        for (int p = 0; p < 4; p++) begin
            need = seg_gap(px[bi], py[bi], px[bj], py[bj], px[p], py[p]) + rad[p];
            if (need > RMAX) begin
                m.sat = 1'b1;
                need = RMAX;
            end
            if (need > r) r = need;
        end
        m.ax = px[bi][CB-1:0];
        m.ay = py[bi][CB-1:0];
        m.bx = px[bj][CB-1:0];
        m.by = py[bj][CB-1:0];
        m.r  = r[CB-2:0];
        return m;
    endfunction

    function automatic logic [IN_W-1:0] pack_pair(capsule_pair_t cp);
        return IN_W'({cp.c1.r, cp.c1.by, cp.c1.bx, cp.c1.ay, cp.c1.ax,
                      cp.c0.r, cp.c0.by, cp.c0.bx, cp.c0.ay, cp.c0.ax});
    endfunction

    task automatic add_pair(longint ax0, longint ay0, longint bx0, longint by0, longint r0,
                            longint ax1, longint ay1, longint bx1, longint by1, longint r1);
        capsule_pair_t cp;
        cp.c0.ax = ax0[CB-1:0]; cp.c0.ay = ay0[CB-1:0];
        cp.c0.bx = bx0[CB-1:0]; cp.c0.by = by0[CB-1:0]; cp.c0.r = r0[CB-2:0];
        cp.c1.ax = ax1[CB-1:0]; cp.c1.ay = ay1[CB-1:0];
        cp.c1.bx = bx1[CB-1:0]; cp.c1.by = by1[CB-1:0]; cp.c1.r = r1[CB-2:0];
        pending_q.push_back(cp);
    endtask

    function automatic longint near_coord(longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // driver: present words from the pending queue, with random idle bursts
    always @(posedge i_clk) begin
        if (s_tvalid && o_s_tready) begin
            merged_q.push_back(merge_capsules(cur_pair));
            words_sent <= words_sent + 1;
        end
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !o_s_tready) begin
            // hold the word until accepted
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_q.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (words_sent + (s_tvalid ? 1 : 0) == drain_at &&
                     (merged_q.size() != 0 || (s_tvalid && o_s_tready))) begin
            s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 12);
            s_tvalid <= 1'b0;
        end else begin
            cur_pair = pending_q.pop_front();
            s_tdata <= pack_pair(cur_pair);
            s_tvalid <= 1'b1;
        end
    end

    // monitor: check each output word against the oldest prediction
    always @(posedge i_clk) begin
        merged_t want;
        if (o_m_tvalid && m_tready && i_rst_n) begin
            if (merged_q.size() == 0) begin
                $error("output word with no prediction waiting");
                n_errors = n_errors + 1;
            end else begin
                want = merged_q.pop_front();
                if (o_m_tdata[CB-1:0] !== want.ax) begin
                    $error("merged_a_x exp %h got %h", want.ax, o_m_tdata[CB-1:0]);
                    n_errors = n_errors + 1;
                end
                if (o_m_tdata[2*CB-1:CB] !== want.ay) begin
                    $error("merged_a_y exp %h got %h", want.ay, o_m_tdata[2*CB-1:CB]);
                    n_errors = n_errors + 1;
                end
                if (o_m_tdata[3*CB-1:2*CB] !== want.bx) begin
                    $error("merged_b_x exp %h got %h", want.bx, o_m_tdata[3*CB-1:2*CB]);
                    n_errors = n_errors + 1;
                end
                if (o_m_tdata[4*CB-1:3*CB] !== want.by) begin
                    $error("merged_b_y exp %h got %h", want.by, o_m_tdata[4*CB-1:3*CB]);
                    n_errors = n_errors + 1;
                end
                if (o_m_tdata[5*CB-2:4*CB] !== want.r) begin
                    $error("merged_radius exp %h got %h", want.r, o_m_tdata[5*CB-2:4*CB]);
                    n_errors = n_errors + 1;
                end
                if (o_m_tuser[0] !== want.sat) begin
                    $error("radius_saturated exp %b got %b", want.sat, o_m_tuser[0]);
                    n_errors = n_errors + 1;
                end
            end
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            wdog <= 0;
        end else if (wdog >= WDOG_MAX) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    always @(posedge i_clk) quiet <= (total_items - words_sent) < QUIET_N;

    initial begin
        longint lo, hi, sp;
        int mode;
        lo = -(64'sd1 << (CB - 1));
        hi = (64'sd1 << (CB - 1)) - 1;
        // directed: extremes, ties, degenerate segments, projection clamps
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(hi, hi, hi, hi, RMAX, hi, hi, hi, hi, RMAX);
        add_pair(lo, lo, lo, lo, 0, lo, lo, lo, lo, 0);
        add_pair(lo, lo, hi, hi, RMAX, lo, hi, hi, lo, RMAX);
        add_pair(lo, 0, hi, 0, 0, 0, lo, 0, hi, 0);
        add_pair(hi, lo, lo, hi, 5, 0, 0, 0, 0, 7);
        add_pair(100, 200, 100, 200, 30, 100, 200, 100, 200, 40);
        add_pair(0, 0, 0, 0, 10, 1000, 0, 1000, 0, 20);
        add_pair(0, 0, 1000, 0, 10, 0, 1000, 1000, 1000, 10);
        add_pair(0, 0, 1000, 1000, 1, 1000, 0, 0, 1000, 2);
        add_pair(0, 0, 1000, 0, 50, 500, 300, 500, -300, 20);
        add_pair(0, 0, 1000, 0, 5, -200, 50, 1200, -50, 500);
        add_pair(0, 0, 2000, 0, 0, 1000, 7, 1001, -3, 0);
        add_pair(-5, -5, 5, 5, 3, 1, -1, -1, 1, RMAX);
        add_pair(hi, 0, lo, 0, 1, 0, 0, 0, 1, RMAX - 1);
        add_pair(0, 0, 300, 400, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 0, 1, 1, -1, -1, 0);
        add_pair(lo, hi, hi, lo, 0, 0, 0, 0, 0, RMAX);
        for (int n = 0; n < N_RAND; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                add_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            end else if (mode < 8) begin
                sp = (mode < 6) ? 3000 : 400000;
                add_pair(near_coord(sp), near_coord(sp), near_coord(sp), near_coord(sp),
                         $urandom_range(0, 2000), near_coord(sp), near_coord(sp),
                         near_coord(sp), near_coord(sp), $urandom_range(0, 2000));
            end else begin
                // coincident or mirrored points make ties and zero-length segments
                sp = near_coord(500);
                add_pair(sp, -sp, sp, -sp, $urandom_range(0, 50), -sp, sp,
                         (mode == 8) ? sp : -sp, -sp, $urandom_range(0, 50));
            end
        end
        total_items = pending_q.size();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (words_sent == total_items && merged_q.size() == 0);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (n_errors == 0 && merged_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cm2d_pkg.sv
rtl/core/cm2d_pair.sv
rtl/core/cm2d_geom.sv
rtl/core/cm2d_root.sv
rtl/core/cm2d_skid.sv
rtl/core/capsule_merge_2d.sv
rtl/core/cm2d_checker.sv
sim/tb_top.sv
